### rtl/core/assert_macros.svh
// Assertion macros used by axis_rotate_vec3.
// The file that uses them provides aclk and the active-low aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop on every rising clock edge outside reset.
`define ARV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checks that post holds in the cycle after pre, outside reset.
`define ARV_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/core/arv_pkg.sv
// Package for the principal-axis point rotator: widths, constants and payload types.
// Used by arv_cell, arv_sincos and axis_rotate_vec3; depends on nothing else.
package arv_pkg;

    // Coordinate and trig resolution.
    localparam int COORD_WIDTH    = 16;
    localparam int TRIG_FRAC_BITS = 15;
    localparam int TRIG_WIDTH     = TRIG_FRAC_BITS + 2;

    localparam int ANGLE_WIDTH = 16;
    localparam int ACT_WIDTH   = 2;

    typedef enum logic [ACT_WIDTH-1:0] {
        ACT_X    = 2'd0,
        ACT_Y    = 2'd1,
        ACT_Z    = 2'd2,
        ACT_PASS = 2'd3
    } arv_act_t;

    // Angle units are 1/64 degree.
    localparam int FULL_TURN    = 23040;
    localparam int QUARTER_TURN = 5760;
    localparam int TURN_WIDTH   = 15;
    localparam int REM_WIDTH    = 13;

    // Radians per angle unit in Q2.30.
    localparam int RAD_WIDTH    = 19;
    localparam int RAD_PER_UNIT = 292818;

    // Series evaluation in Q2.30.
    localparam int FIX_FRAC    = 30;
    localparam int X_WIDTH     = 31;
    localparam int X2_WIDTH    = 32;
    localparam int T_WIDTH     = 31;
    localparam int P_WIDTH     = 32;
    localparam int RECIP_WIDTH = 32;
    localparam int DIV_WIDTH   = 8;

    localparam logic [T_WIDTH-1:0] ONE_Q30 = T_WIDTH'(1) << FIX_FRAC;

    localparam int SIN_TERMS   = 6;
    localparam int COS_TERMS   = 7;
    localparam int CELL_STAGES = 3;

    localparam logic [DIV_WIDTH-1:0] SIN_DIV [SIN_TERMS] =
        '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [DIV_WIDTH-1:0] COS_DIV [COS_TERMS] =
        '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

    // floor(2^32 / d); the quotient estimate is then low by at most one.
    localparam logic [RECIP_WIDTH-1:0] SIN_RECIP [SIN_TERMS] = '{
        32'((64'd1 << 32) / 64'd156), 32'((64'd1 << 32) / 64'd110),
        32'((64'd1 << 32) / 64'd72),  32'((64'd1 << 32) / 64'd42),
        32'((64'd1 << 32) / 64'd20),  32'((64'd1 << 32) / 64'd6)
    };
    localparam logic [RECIP_WIDTH-1:0] COS_RECIP [COS_TERMS] = '{
        32'((64'd1 << 32) / 64'd182), 32'((64'd1 << 32) / 64'd132),
        32'((64'd1 << 32) / 64'd90),  32'((64'd1 << 32) / 64'd56),
        32'((64'd1 << 32) / 64'd30),  32'((64'd1 << 32) / 64'd12),
        32'((64'd1 << 32) / 64'd2)
    };

    // Angle reduction, radians, square, the cosine chain, then quadrant mapping.
    localparam int SC_LATENCY = 3 + CELL_STAGES * COS_TERMS + 1;

    // Rotation sums.
    localparam int PROD_WIDTH = COORD_WIDTH + TRIG_WIDTH;
    localparam int SUM_WIDTH  = PROD_WIDTH + 2;
    localparam int RND_WIDTH  = SUM_WIDTH - TRIG_FRAC_BITS;

    // Data handed from one series cell to the next.
    typedef struct packed {
        logic [X2_WIDTH-1:0] x2;
        logic [T_WIDTH-1:0]  t;
        logic [X_WIDTH-1:0]  x;
        logic [1:0]          quad;
    } arv_lane_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] in_x;
        logic signed [COORD_WIDTH-1:0] in_y;
        logic signed [COORD_WIDTH-1:0] in_z;
        logic signed [ANGLE_WIDTH-1:0] angle;
        logic [ACT_WIDTH-1:0]          action;
    } arv_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
        logic                          saturated;
    } arv_out_t;

endpackage

### rtl/core/arv_cell.sv
// One Horner step of the sine/cosine series: t' = clamp(1 - ((x2 * t) >> 30) / d).
// Three register stages; depends on arv_pkg.
module arv_cell (
    input  logic                                aclk,
    input  logic                                en,
    input  logic [arv_pkg::DIV_WIDTH-1:0]       divisor,
    input  logic [arv_pkg::RECIP_WIDTH-1:0]     recip,
    input  arv_pkg::arv_lane_t                  lane_i,
    output arv_pkg::arv_lane_t                  lane_o
);
    import arv_pkg::*;

    localparam int XT_WIDTH = X2_WIDTH + T_WIDTH;
    localparam int PM_WIDTH = P_WIDTH + RECIP_WIDTH;
    localparam int QD_WIDTH = P_WIDTH + DIV_WIDTH;

    logic [XT_WIDTH-1:0] xt;
    logic [PM_WIDTH-1:0] pm;
    logic [QD_WIDTH-1:0] qd;
    logic [QD_WIDTH-1:0] rem;
    logic [P_WIDTH-1:0]  quo;
    arv_lane_t           lane_next;

    arv_lane_t           lane_a_reg;
    arv_lane_t           lane_b_reg;
    arv_lane_t           lane_c_reg;
    logic [P_WIDTH-1:0]  p_a_reg;
    logic [P_WIDTH-1:0]  p_b_reg;
    logic [P_WIDTH-1:0]  qe_b_reg;

    assign xt = XT_WIDTH'(lane_i.x2) * XT_WIDTH'(lane_i.t);
    assign pm = PM_WIDTH'(p_a_reg) * PM_WIDTH'(recip);

    // The reciprocal estimate is at most one low; one compare fixes it.
    always_comb begin
        qd  = QD_WIDTH'(qe_b_reg) * QD_WIDTH'(divisor);
        rem = QD_WIDTH'(p_b_reg) - qd;
        quo = qe_b_reg + P_WIDTH'(rem >= QD_WIDTH'(divisor));
        lane_next = lane_b_reg;
        if (quo >= P_WIDTH'(ONE_Q30)) begin
            lane_next.t = '0;
        end else begin
            lane_next.t = T_WIDTH'(P_WIDTH'(ONE_Q30) - quo);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_a_reg <= lane_i;
            p_a_reg    <= xt[FIX_FRAC +: P_WIDTH];
            lane_b_reg <= lane_a_reg;
            p_b_reg    <= p_a_reg;
            qe_b_reg   <= pm[RECIP_WIDTH +: P_WIDTH];
            lane_c_reg <= lane_next;
        end
    end

    assign lane_o = lane_c_reg;

endmodule

### rtl/core/arv_sincos.sv
// Sine and cosine of an angle in 1/64 degree units, as signed TRIG_FRAC_BITS fractions.
// Angle reduction, then rows of arv_cell for the two series; depends on arv_pkg.
module arv_sincos (
    input  logic                                      aclk,
    input  logic                                      en,
    input  logic signed [arv_pkg::ANGLE_WIDTH-1:0]    angle,
    output logic signed [arv_pkg::TRIG_WIDTH-1:0]     sin_o,
    output logic signed [arv_pkg::TRIG_WIDTH-1:0]     cos_o
);
    import arv_pkg::*;

    localparam int EXT_WIDTH    = ANGLE_WIDTH + 2;
    localparam int TRIG_SHIFT   = FIX_FRAC - TRIG_FRAC_BITS;
    localparam int SPROD_WIDTH  = X_WIDTH + T_WIDTH;
    localparam int XSQ_WIDTH    = 2 * X_WIDTH;
    localparam int XR_WIDTH     = REM_WIDTH + RAD_WIDTH;

    localparam logic signed [EXT_WIDTH-1:0] FULL_S = EXT_WIDTH'(FULL_TURN);
    localparam logic [TURN_WIDTH-1:0] QTR_1 = TURN_WIDTH'(QUARTER_TURN);
    localparam logic [TURN_WIDTH-1:0] QTR_2 = TURN_WIDTH'(2 * QUARTER_TURN);
    localparam logic [TURN_WIDTH-1:0] QTR_3 = TURN_WIDTH'(3 * QUARTER_TURN);
    localparam logic [RAD_WIDTH-1:0]  RAD_K = RAD_WIDTH'(RAD_PER_UNIT);
    localparam logic [T_WIDTH:0]      TRIG_HALF = (T_WIDTH+1)'((64'd1 << TRIG_SHIFT) >> 1);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    function automatic logic [TRIG_FRAC_BITS:0] to_trig(input logic [T_WIDTH-1:0] v);
        logic [T_WIDTH:0] biased;
        biased  = (T_WIDTH+1)'(v) + TRIG_HALF;
        to_trig = (TRIG_FRAC_BITS+1)'(biased >> TRIG_SHIFT);
    endfunction

    logic signed [EXT_WIDTH-1:0] ang_ext;
    logic signed [EXT_WIDTH-1:0] ang_red;
    logic [TURN_WIDTH-1:0]       turn;
    logic [1:0]                  quad_next;
    logic [REM_WIDTH-1:0]        rem_next;
    logic [XR_WIDTH-1:0]         xr;
    logic [XSQ_WIDTH-1:0]        xsq;
    logic [SPROD_WIDTH-1:0]      sprod;
    logic [T_WIDTH-1:0]          sin_lin;
    logic [TRIG_FRAC_BITS:0]     cos_mag;
    logic signed [TRIG_WIDTH-1:0] sp;
    logic signed [TRIG_WIDTH-1:0] cp;
    logic signed [TRIG_WIDTH-1:0] sin_next;
    logic signed [TRIG_WIDTH-1:0] cos_next;

    logic [1:0]                   quad_s1_reg;
    logic [REM_WIDTH-1:0]         rem_s1_reg;
    logic [1:0]                   quad_s2_reg;
    logic [X_WIDTH-1:0]           x_s2_reg;
    arv_lane_t                    lane_s3_reg;
    logic [SPROD_WIDTH-1:0]       sprod_reg;
    logic [TRIG_FRAC_BITS:0]      sin_rnd_reg;
    logic [TRIG_FRAC_BITS:0]      sin_dly_reg;
    logic signed [TRIG_WIDTH-1:0] sin_reg;
    logic signed [TRIG_WIDTH-1:0] cos_reg;

    arv_lane_t sin_lane [SIN_TERMS+1];
    arv_lane_t cos_lane [COS_TERMS+1];

    // Reduce the angle into one turn, then split off the quadrant.
    always_comb begin
        ang_ext = EXT_WIDTH'(angle);
        if (ang_ext < -FULL_S) begin
            ang_red = ang_ext + FULL_S + FULL_S;
        end else if (ang_ext < 0) begin
            ang_red = ang_ext + FULL_S;
        end else if (ang_ext >= FULL_S) begin
            ang_red = ang_ext - FULL_S;
        end else begin
            ang_red = ang_ext;
        end
        turn = ang_red[TURN_WIDTH-1:0];
        if (turn >= QTR_3) begin
            quad_next = QUAD_3;
            rem_next  = REM_WIDTH'(turn - QTR_3);
        end else if (turn >= QTR_2) begin
            quad_next = QUAD_2;
            rem_next  = REM_WIDTH'(turn - QTR_2);
        end else if (turn >= QTR_1) begin
            quad_next = QUAD_1;
            rem_next  = REM_WIDTH'(turn - QTR_1);
        end else begin
            quad_next = QUAD_0;
            rem_next  = REM_WIDTH'(turn);
        end
    end

    assign xr  = XR_WIDTH'(rem_s1_reg) * XR_WIDTH'(RAD_K);
    assign xsq = XSQ_WIDTH'(x_s2_reg) * XSQ_WIDTH'(x_s2_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            quad_s1_reg      <= quad_next;
            rem_s1_reg       <= rem_next;
            quad_s2_reg      <= quad_s1_reg;
            x_s2_reg         <= X_WIDTH'(xr);
            lane_s3_reg.x2   <= xsq[FIX_FRAC +: X2_WIDTH];
            lane_s3_reg.t    <= ONE_Q30;
            lane_s3_reg.x    <= x_s2_reg;
            lane_s3_reg.quad <= quad_s2_reg;
        end
    end

    assign sin_lane[0] = lane_s3_reg;
    assign cos_lane[0] = lane_s3_reg;

    for (genvar i = 0; i < SIN_TERMS; i++) begin : g_sin
        arv_cell u_cell (
            .aclk    (aclk),
            .en      (en),
            .divisor (SIN_DIV[i]),
            .recip   (SIN_RECIP[i]),
            .lane_i  (sin_lane[i]),
            .lane_o  (sin_lane[i+1])
        );
    end

    for (genvar i = 0; i < COS_TERMS; i++) begin : g_cos
        arv_cell u_cell (
            .aclk    (aclk),
            .en      (en),
            .divisor (COS_DIV[i]),
            .recip   (COS_RECIP[i]),
            .lane_i  (cos_lane[i]),
            .lane_o  (cos_lane[i+1])
        );
    end

    // The sine row is one cell shorter; the final x multiply, rounding and one
    // spare register bring it level with the cosine row.
    assign sprod = SPROD_WIDTH'(sin_lane[SIN_TERMS].x) * SPROD_WIDTH'(sin_lane[SIN_TERMS].t);

    always_comb begin
        sin_lin = sprod_reg[FIX_FRAC +: T_WIDTH];
        if (sin_lin > ONE_Q30) begin
            sin_lin = ONE_Q30;
        end
        cos_mag = to_trig(cos_lane[COS_TERMS].t);
        sp = signed'({1'b0, sin_dly_reg});
        cp = signed'({1'b0, cos_mag});
        case (cos_lane[COS_TERMS].quad)
            QUAD_0: begin
                sin_next = sp;
                cos_next = cp;
            end
            QUAD_1: begin
                sin_next = cp;
                cos_next = -sp;
            end
            QUAD_2: begin
                sin_next = -sp;
                cos_next = -cp;
            end
            QUAD_3: begin
                sin_next = -cp;
                cos_next = sp;
            end
            default: begin
                sin_next = sp;
                cos_next = cp;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sprod_reg   <= sprod;
            sin_rnd_reg <= to_trig(sin_lin);
            sin_dly_reg <= sin_rnd_reg;
            sin_reg     <= sin_next;
            cos_reg     <= cos_next;
        end
    end

    assign sin_o = sin_reg;
    assign cos_o = cos_reg;

endmodule

### rtl/core/axis_rotate_vec3.sv
// Top level of the principal-axis point rotator: pipeline, rotation sums, output buffer.
// Depends on arv_pkg, arv_sincos (with arv_cell) and assert_macros.svh.
//
// Channel  Dir  Handshake          Payload
// s_       in   s_valid, s_ready   s_data : arv_in_t  (in_x, in_y, in_z, angle, action)
// m_       out  m_valid, m_ready   m_data : arv_out_t (out_x, out_y, out_z, saturated)
//
// One transaction is accepted per clock while the skid register is empty (s_ready high).
// Most of the pipeline depth is the seven-cell cosine row, three register stages per cell.
// aresetn is synchronous and clears only the valid bits; no clearing pass is needed.
// A stalled output parks its result in a skid register; s_ready drops only while it is full.
`include "assert_macros.svh"

module axis_rotate_vec3 (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  arv_pkg::arv_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output arv_pkg::arv_out_t m_data
);
    import arv_pkg::*;

    localparam logic signed [SUM_WIDTH-1:0] RND_HALF = SUM_WIDTH'(1) << (TRIG_FRAC_BITS - 1);

    // Rounds a Q(8+TRIG_FRAC_BITS) sum half up to Q8.8 and saturates; MSB is the clip flag.
    function automatic logic [COORD_WIDTH:0] round_sat(input logic signed [SUM_WIDTH-1:0] acc);
        logic signed [SUM_WIDTH-1:0] biased;
        logic signed [RND_WIDTH-1:0] shifted;
        logic                        over;
        biased  = acc + RND_HALF;
        shifted = RND_WIDTH'(biased >>> TRIG_FRAC_BITS);
        over    = (shifted[RND_WIDTH-1:COORD_WIDTH-1] != '0) &&
                  (shifted[RND_WIDTH-1:COORD_WIDTH-1] != '1);
        if (!over) begin
            round_sat = {1'b0, shifted[COORD_WIDTH-1:0]};
        end else if (shifted[RND_WIDTH-1]) begin
            round_sat = {1'b1, 1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            round_sat = {1'b1, 1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    logic                          adv;
    logic signed [TRIG_WIDTH-1:0]  sin_w;
    logic signed [TRIG_WIDTH-1:0]  cos_w;
    logic signed [COORD_WIDTH-1:0] u_sel;
    logic signed [COORD_WIDTH-1:0] v_sel;
    logic signed [SUM_WIDTH-1:0]   acc_u;
    logic signed [SUM_WIDTH-1:0]   acc_v;
    logic [COORD_WIDTH:0]          res_u;
    logic [COORD_WIDTH:0]          res_v;
    arv_out_t                      fin;

    logic [SC_LATENCY-1:0]         vld_reg;
    arv_in_t                       item_reg [SC_LATENCY];
    logic                          prod_valid_reg;
    arv_in_t                       prod_item_reg;
    logic signed [PROD_WIDTH-1:0]  cu_reg;
    logic signed [PROD_WIDTH-1:0]  sv_reg;
    logic signed [PROD_WIDTH-1:0]  su_reg;
    logic signed [PROD_WIDTH-1:0]  cv_reg;
    logic                          m_valid_reg;
    arv_out_t                      out_data_reg;
    logic                          skid_valid_reg;
    arv_out_t                      skid_data_reg;

    // The whole pipeline moves together; it halts only while the skid register is full.
    assign adv     = !skid_valid_reg;
    assign s_ready = adv;

    arv_sincos u_sincos (
        .aclk  (aclk),
        .en    (adv),
        .angle (s_data.angle),
        .sin_o (sin_w),
        .cos_o (cos_w)
    );

    // The two coordinates that move, in the order the rotation matrix takes them.
    always_comb begin
        case (item_reg[SC_LATENCY-1].action)
            ACT_X: begin
                u_sel = item_reg[SC_LATENCY-1].in_y;
                v_sel = item_reg[SC_LATENCY-1].in_z;
            end
            ACT_Y: begin
                u_sel = item_reg[SC_LATENCY-1].in_x;
                v_sel = item_reg[SC_LATENCY-1].in_z;
            end
            ACT_Z: begin
                u_sel = item_reg[SC_LATENCY-1].in_x;
                v_sel = item_reg[SC_LATENCY-1].in_y;
            end
            default: begin
                u_sel = item_reg[SC_LATENCY-1].in_x;
                v_sel = item_reg[SC_LATENCY-1].in_y;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg        <= '0;
            prod_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg        <= {vld_reg[SC_LATENCY-2:0], s_valid};
            prod_valid_reg <= vld_reg[SC_LATENCY-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg[0] <= s_data;
            for (int k = 1; k < SC_LATENCY; k++) begin
                item_reg[k] <= item_reg[k-1];
            end
            prod_item_reg <= item_reg[SC_LATENCY-1];
            cu_reg        <= PROD_WIDTH'(cos_w) * PROD_WIDTH'(u_sel);
            sv_reg        <= PROD_WIDTH'(sin_w) * PROD_WIDTH'(v_sel);
            su_reg        <= PROD_WIDTH'(sin_w) * PROD_WIDTH'(u_sel);
            cv_reg        <= PROD_WIDTH'(cos_w) * PROD_WIDTH'(v_sel);
        end
    end

    // Rotation about Y runs the other way round, so the sine terms swap sign.
    always_comb begin
        if (prod_item_reg.action == ACT_Y) begin
            acc_u = SUM_WIDTH'(cu_reg) + SUM_WIDTH'(sv_reg);
            acc_v = SUM_WIDTH'(cv_reg) - SUM_WIDTH'(su_reg);
        end else begin
            acc_u = SUM_WIDTH'(cu_reg) - SUM_WIDTH'(sv_reg);
            acc_v = SUM_WIDTH'(su_reg) + SUM_WIDTH'(cv_reg);
        end
        res_u = round_sat(acc_u);
        res_v = round_sat(acc_v);

        fin.out_x     = prod_item_reg.in_x;
        fin.out_y     = prod_item_reg.in_y;
        fin.out_z     = prod_item_reg.in_z;
        fin.saturated = 1'b0;
        case (prod_item_reg.action)
            ACT_X: begin
                fin.out_y     = res_u[COORD_WIDTH-1:0];
                fin.out_z     = res_v[COORD_WIDTH-1:0];
                fin.saturated = res_u[COORD_WIDTH] | res_v[COORD_WIDTH];
            end
            ACT_Y: begin
                fin.out_x     = res_u[COORD_WIDTH-1:0];
                fin.out_z     = res_v[COORD_WIDTH-1:0];
                fin.saturated = res_u[COORD_WIDTH] | res_v[COORD_WIDTH];
            end
            ACT_Z: begin
                fin.out_x     = res_u[COORD_WIDTH-1:0];
                fin.out_y     = res_v[COORD_WIDTH-1:0];
                fin.saturated = res_u[COORD_WIDTH] | res_v[COORD_WIDTH];
            end
            ACT_PASS: begin
                fin.saturated = 1'b0;
            end
            default: begin
                fin.saturated = 1'b0;
            end
        endcase
    end

    // Output register plus skid register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (prod_valid_reg) begin
            if (m_valid_reg && !m_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                m_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (prod_valid_reg) begin
            if (m_valid_reg && !m_ready) begin
                skid_data_reg <= fin;
            end else begin
                out_data_reg <= fin;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_data_reg;

    `ARV_ASSERT(a_skid_needs_out, skid_valid_reg |-> m_valid_reg, "skid register full with output register empty")
    `ARV_ASSERT_NEXT(a_prod_lands, prod_valid_reg && !skid_valid_reg, m_valid_reg, "finished transaction did not reach the output")
    `ARV_ASSERT_NEXT(a_stall_holds, prod_valid_reg && skid_valid_reg, prod_valid_reg, "stalled pipeline lost a transaction")
    `ARV_ASSERT_NEXT(a_skid_drains, skid_valid_reg && m_ready, !skid_valid_reg && m_valid_reg, "skid register did not drain into the output")

endmodule
